@@ hdl/wavp_pkg.sv @@
// ----------------------------------------------------------------------------
// WAV PCM parser package
// Result word layout, result kinds, fault codes and RIFF chunk tags.
// ----------------------------------------------------------------------------
package wavp_pkg;

    localparam logic [1:0] KIND_FRAME  = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_FAULT  = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam logic [2:0] FAULT_NOT_WAVE  = 3'd0;
    localparam logic [2:0] FAULT_FMT       = 3'd1;
    localparam logic [2:0] FAULT_TAG       = 3'd2;
    localparam logic [2:0] FAULT_CHANNELS  = 3'd3;
    localparam logic [2:0] FAULT_RATE      = 3'd4;
    localparam logic [2:0] FAULT_BITS      = 3'd5;
    localparam logic [2:0] FAULT_NO_DATA   = 3'd6;
    localparam logic [2:0] FAULT_UNBOUNDED = 3'd7;

    localparam logic [31:0] TAG_RIFF       = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE       = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT        = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA       = 32'h6461_7461;
    localparam logic [31:0] SIZE_UNBOUNDED = 32'hFFFF_FFFF;
    localparam logic [31:0] FMT_BODY_BYTES = 32'd16;
    localparam logic [7:0]  SIGN_FLIP      = 8'h80;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [31:0]        sample_rate;
        logic               stereo;
        logic               wide_samples;
        logic [2:0]         fault_code;
        logic               data_done;
        logic               input_ended;
    } t_result;

endpackage

@@ hdl/wav_pcm_stream_parser_unit.sv @@
// ----------------------------------------------------------------------------
// WAV PCM stream parser
// The parser takes one byte per cycle while the buffer word is empty; its step
// is a single registered pass.
// A two-word output buffer keeps bytes flowing while one result waits.
// Synchronous active-low reset returns the parser to the file header.
// Parses RIFF/WAVE into format, fault, end and 16-bit stereo frame words.
// ----------------------------------------------------------------------------
module wav_pcm_stream_parser_unit
    import wavp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_in_byte,
    input  logic               i_end_of_input,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_kind,
    output logic signed [15:0] o_left,
    output logic signed [15:0] o_right,
    output logic [31:0]        o_sample_rate,
    output logic               o_stereo,
    output logic               o_wide_samples,
    output logic [2:0]         o_fault_code,
    output logic               o_data_done,
    output logic               o_input_ended
);

    localparam logic [3:0] PH_HDR       = 4'd0;
    localparam logic [3:0] PH_FMT_HEAD  = 4'd1;
    localparam logic [3:0] PH_FMT_SKIP  = 4'd2;
    localparam logic [3:0] PH_FMT_BODY  = 4'd3;
    localparam logic [3:0] PH_FMT_REST  = 4'd4;
    localparam logic [3:0] PH_DATA_HEAD = 4'd5;
    localparam logic [3:0] PH_DATA_SKIP = 4'd6;
    localparam logic [3:0] PH_DATA      = 4'd7;
    localparam logic [3:0] PH_DONE      = 4'd8;
    localparam logic [3:0] PH_FAULT     = 4'd9;

    logic [3:0]  r_phase, n_phase;
    logic [3:0]  r_cnt, n_cnt;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_size, n_size;
    logic [15:0] r_ftag, n_ftag;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;
    logic [31:0] r_left_cnt, n_left_cnt;
    logic [7:0]  r_low, n_low;
    logic [15:0] r_lhold, n_lhold;
    logic        r_half, n_half;

    t_result     n_res;
    logic        n_have;
    logic        head_done;
    logic        sample_ok;
    logic [15:0] sample;

    t_result     r_out;
    t_result     r_skid;
    logic        r_out_valid;
    logic        r_skid_valid;
    logic        accept;
    logic        out_take;

    assign accept     = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skid_valid;

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_tag      = r_tag;
        n_size     = r_size;
        n_ftag     = r_ftag;
        n_chan     = r_chan;
        n_rate     = r_rate;
        n_bits     = r_bits;
        n_left_cnt = r_left_cnt;
        n_low      = r_low;
        n_lhold    = r_lhold;
        n_half     = r_half;
        n_res      = '0;
        n_have     = 1'b0;
        head_done  = 1'b0;
        sample_ok  = 1'b0;
        sample     = '0;

        if (r_phase == PH_FMT_HEAD || r_phase == PH_DATA_HEAD) begin
            if (r_cnt[2:0] < 3'd4) begin
                n_tag = {r_tag[23:0], i_in_byte};
            end
            case (r_cnt[2:0])
                3'd4:    n_size = {24'd0, i_in_byte};
                3'd5:    n_size[15:8] = i_in_byte;
                3'd6:    n_size[23:16] = i_in_byte;
                3'd7:    n_size[31:24] = i_in_byte;
                default: n_size = r_size;
            endcase
            if (r_cnt[2:0] == 3'd7) begin
                n_cnt     = '0;
                head_done = (n_size != '0);
            end else begin
                n_cnt = r_cnt + 4'd1;
            end
        end

        case (r_phase)
            PH_HDR: begin
                if (r_cnt < 4'd4 || r_cnt >= 4'd8) begin
                    n_tag = {r_tag[23:0], i_in_byte};
                end
                if (r_cnt == 4'd3 && n_tag != TAG_RIFF) begin
                    n_have = 1'b1;
                    n_res.kind = KIND_FAULT;
                    n_res.fault_code = FAULT_NOT_WAVE;
                    n_phase = PH_FAULT;
                end else if (r_cnt >= 4'd11) begin
                    n_cnt = '0;
                    if (n_tag != TAG_WAVE) begin
                        n_have = 1'b1;
                        n_res.kind = KIND_FAULT;
                        n_res.fault_code = FAULT_NOT_WAVE;
                        n_phase = PH_FAULT;
                    end else begin
                        n_phase = PH_FMT_HEAD;
                    end
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            PH_FMT_HEAD: begin
                if (head_done) begin
                    if (n_tag != TAG_FMT) begin
                        n_phase = PH_FMT_SKIP;
                    end else if (n_size < FMT_BODY_BYTES) begin
                        n_have = 1'b1;
                        n_res.kind = KIND_FAULT;
                        n_res.fault_code = FAULT_FMT;
                        n_phase = PH_FAULT;
                    end else begin
                        n_phase = PH_FMT_BODY;
                    end
                end
            end
            PH_FMT_SKIP, PH_FMT_REST, PH_DATA_SKIP: begin
                n_size = r_size - 32'd1;
                if (n_size == '0) begin
                    n_phase = (r_phase == PH_FMT_SKIP) ? PH_FMT_HEAD : PH_DATA_HEAD;
                end
            end
            PH_FMT_BODY: begin
                case (r_cnt)
                    4'd0:    n_ftag = {8'd0, i_in_byte};
                    4'd1:    n_ftag[15:8] = i_in_byte;
                    4'd2:    n_chan = {8'd0, i_in_byte};
                    4'd3:    n_chan[15:8] = i_in_byte;
                    4'd4:    n_rate = {24'd0, i_in_byte};
                    4'd5:    n_rate[15:8] = i_in_byte;
                    4'd6:    n_rate[23:16] = i_in_byte;
                    4'd7:    n_rate[31:24] = i_in_byte;
                    4'd14:   n_bits = {8'd0, i_in_byte};
                    4'd15:   n_bits[15:8] = i_in_byte;
                    default: n_ftag = r_ftag;
                endcase
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_res.kind = KIND_FAULT;
                    n_phase = PH_FAULT;
                    n_have = 1'b1;
                    if (n_ftag != 16'd1) begin
                        n_res.fault_code = FAULT_TAG;
                    end else if (n_chan != 16'd1 && n_chan != 16'd2) begin
                        n_res.fault_code = FAULT_CHANNELS;
                    end else if (n_rate == '0) begin
                        n_res.fault_code = FAULT_RATE;
                    end else if (n_bits != 16'd8 && n_bits != 16'd16) begin
                        n_res.fault_code = FAULT_BITS;
                    end else begin
                        n_have = 1'b0;
                        n_res = '0;
                        if (r_size > FMT_BODY_BYTES) begin
                            n_size = r_size - FMT_BODY_BYTES;
                            n_phase = PH_FMT_REST;
                        end else begin
                            n_phase = PH_DATA_HEAD;
                        end
                    end
                end
            end
            PH_DATA_HEAD: begin
                if (head_done) begin
                    if (n_tag != TAG_DATA) begin
                        n_phase = PH_DATA_SKIP;
                    end else if (n_size == SIZE_UNBOUNDED) begin
                        n_have = 1'b1;
                        n_res.kind = KIND_FAULT;
                        n_res.fault_code = FAULT_UNBOUNDED;
                        n_phase = PH_FAULT;
                    end else begin
                        n_left_cnt = n_size;
                        n_cnt = '0;
                        n_half = 1'b0;
                        n_phase = PH_DATA;
                        n_have = 1'b1;
                        n_res.kind = KIND_FORMAT;
                        n_res.sample_rate = r_rate;
                        n_res.stereo = (r_chan == 16'd2);
                        n_res.wide_samples = (r_bits == 16'd16);
                    end
                end
            end
            PH_DATA: begin
                n_cnt = {3'd0, ~r_cnt[0]};
                n_left_cnt = r_left_cnt - 32'd1;
                if (r_bits != 16'd16) begin
                    sample = {i_in_byte ^ SIGN_FLIP, i_in_byte};
                    sample_ok = 1'b1;
                end else if (!r_cnt[0]) begin
                    n_low = i_in_byte;
                end else begin
                    sample = {i_in_byte, r_low};
                    sample_ok = 1'b1;
                end
                if (sample_ok) begin
                    if (r_chan == 16'd2) begin
                        n_half = ~r_half;
                        if (!r_half) begin
                            n_lhold = sample;
                        end else begin
                            n_have = 1'b1;
                            n_res.left = r_lhold;
                            n_res.right = sample;
                        end
                    end else begin
                        n_have = 1'b1;
                        n_res.left = sample;
                        n_res.right = sample;
                    end
                end
                if (n_left_cnt == '0) begin
                    n_phase = PH_DONE;
                    n_res.data_done = n_have;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        if (i_end_of_input) begin
            if (!n_have) begin
                n_have = 1'b1;
                n_res.kind = KIND_FAULT;
                case (n_phase)
                    PH_HDR:  n_res.fault_code = FAULT_NOT_WAVE;
                    PH_FMT_HEAD, PH_FMT_SKIP, PH_FMT_BODY: n_res.fault_code = FAULT_FMT;
                    PH_FMT_REST, PH_DATA_HEAD, PH_DATA_SKIP: n_res.fault_code = FAULT_NO_DATA;
                    default: n_res.kind = KIND_END;
                endcase
            end
            n_res.input_ended = 1'b1;
            n_phase    = PH_HDR;
            n_cnt      = '0;
            n_tag      = '0;
            n_size     = '0;
            n_ftag     = '0;
            n_chan     = '0;
            n_rate     = '0;
            n_bits     = '0;
            n_left_cnt = '0;
            n_low      = '0;
            n_lhold    = '0;
            n_half     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR;
            r_cnt      <= '0;
            r_tag      <= '0;
            r_size     <= '0;
            r_ftag     <= '0;
            r_chan     <= '0;
            r_rate     <= '0;
            r_bits     <= '0;
            r_left_cnt <= '0;
            r_low      <= '0;
            r_lhold    <= '0;
            r_half     <= 1'b0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_tag      <= n_tag;
            r_size     <= n_size;
            r_ftag     <= n_ftag;
            r_chan     <= n_chan;
            r_rate     <= n_rate;
            r_bits     <= n_bits;
            r_left_cnt <= n_left_cnt;
            r_low      <= n_low;
            r_lhold    <= n_lhold;
            r_half     <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (accept && n_have) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (accept && n_have) begin
            if (r_out_valid && !out_take) begin
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_left         = r_out.left;
    assign o_right        = r_out.right;
    assign o_sample_rate  = r_out.sample_rate;
    assign o_stereo       = r_out.stereo;
    assign o_wide_samples = r_out.wide_samples;
    assign o_fault_code   = r_out.fault_code;
    assign o_data_done    = r_out.data_done;
    assign o_input_ended  = r_out.input_ended;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("Buffered result present while the output register is empty.");

    a_restart_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_input) |=> (r_phase == PH_HDR && r_cnt == '0))
        else $error("Parser did not restart after the last byte of a file.");

    a_done_on_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_data_done) |-> (o_kind == KIND_FRAME))
        else $error("Data completion flagged on a word that is not a frame.");

    a_format_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_FORMAT) |-> (o_fault_code == '0 && o_sample_rate != '0))
        else $error("Format word carries a fault code or a zero rate.");

    a_fault_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_end_of_input && n_have && n_res.kind == KIND_FAULT)
        |=> (r_phase == PH_FAULT))
        else $error("Parser kept running after reporting a fault.");
`endif

endmodule

@@ dv/tb_wav_pcm_stream_parser_unit.sv @@
// ----------------------------------------------------------------------------
// WAV PCM stream parser testbench
// Sends whole WAV files, some well-formed, some damaged, cut short or pure
// noise, one byte per word. It predicts every result word from its own copy
// of the parser state and checks the words field by field as they leave the
// block. Both sides idle in random bursts, the output is once held off long
// enough to back up the input, and the sender once waits for a full drain.
// ----------------------------------------------------------------------------
module tb_wav_pcm_stream_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import wavp_pkg::*;

    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_BYTES  = 1050;
    localparam int DRAIN_AT      = 600;
    localparam int HOLD_AT       = 250;
    localparam int LONG_HOLD     = 400;
    localparam int CALM_FROM     = 400;
    localparam int CALM_TO       = 480;
    localparam int TAIL_QUIET    = 150;
    localparam int SETTLE_CYCLES = 20;
    localparam int TIMEOUT_NS    = 2_000_000;
    localparam int MAX_PRINTS    = 50;

    typedef enum logic [3:0] {
        ST_FILE_HDR, ST_FMT_HDR, ST_FMT_SKIP, ST_FMT_BODY, ST_FMT_REST,
        ST_DATA_HDR, ST_DATA_SKIP, ST_SAMPLES, ST_DONE, ST_FAULTED
    } t_parse_phase;

    typedef enum int {
        SHAPE_NOISE, SHAPE_BAD_HEADER, SHAPE_SHORT_FMT, SHAPE_BAD_TAG,
        SHAPE_BAD_CHANNELS, SHAPE_ZERO_RATE, SHAPE_BAD_DEPTH, SHAPE_NO_DATA,
        SHAPE_UNBOUNDED, SHAPE_CUT, SHAPE_SHORT_DATA, SHAPE_CLEAN
    } t_shape;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_byte_item;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic [7:0]         i_in_byte      = '0;
    logic               i_end_of_input = 1'b0;
    logic               i_out_stall    = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [1:0]         o_kind;
    logic signed [15:0] o_left;
    logic signed [15:0] o_right;
    logic [31:0]        o_sample_rate;
    logic               o_stereo;
    logic               o_wide_samples;
    logic [2:0]         o_fault_code;
    logic               o_data_done;
    logic               o_input_ended;

    t_byte_item pending_bytes[$];
    t_result    expected_words[$];
    logic [7:0] wav_image[$];
    t_byte_item next_item;
    t_result    seen_word;

    int sent_count     = 0;
    int items_total    = 0;
    int checked_count  = 0;
    int mismatch_count = 0;
    int src_gap        = 0;
    int sink_hold      = 0;
    bit drain_wait     = 1'b0;
    bit long_hold_done = 1'b0;

    t_parse_phase phase;
    logic [31:0]  pos_count;
    logic [31:0]  tag_shift;
    logic [31:0]  size_left;
    logic [15:0]  fmt_tag;
    logic [15:0]  chan_count;
    logic [31:0]  rate_field;
    logic [15:0]  depth_field;
    logic [31:0]  data_remaining;
    logic [7:0]   low_hold;
    logic [15:0]  left_keep;
    logic         right_pending;
    t_result      word_out;
    logic         word_ready;

    wav_pcm_stream_parser_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_left         (o_left),
        .o_right        (o_right),
        .o_sample_rate  (o_sample_rate),
        .o_stereo       (o_stereo),
        .o_wide_samples (o_wide_samples),
        .o_fault_code   (o_fault_code),
        .o_data_done    (o_data_done),
        .o_input_ended  (o_input_ended)
    );

    always begin
        #4;
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
    end

    function automatic void clear_parser();
        phase          = ST_FILE_HDR;
        pos_count      = '0;
        tag_shift      = '0;
        size_left      = '0;
        fmt_tag        = '0;
        chan_count     = '0;
        rate_field     = '0;
        depth_field    = '0;
        data_remaining = '0;
        low_hold       = '0;
        left_keep      = '0;
        right_pending  = 1'b0;
    endfunction

    function automatic void raise_fault(input logic [2:0] code);
        word_out.kind       = KIND_FAULT;
        word_out.fault_code = code;
        word_ready          = 1'b1;
        phase               = ST_FAULTED;
    endfunction

    function automatic logic take_chunk_head(input logic [7:0] din);
        logic [2:0] idx;
        idx = pos_count[2:0];
        if (idx < 3'd4) begin
            tag_shift = {tag_shift[23:0], din};
        end else if (idx == 3'd4) begin
            size_left = {24'h0, din};
        end else begin
            size_left[8 * (int'(idx) - 4) +: 8] = din;
        end
        if (idx == 3'd7) begin
            pos_count = '0;
            return 1'b1;
        end
        pos_count = 32'(idx) + 32'd1;
        return 1'b0;
    endfunction

    function automatic void take_fmt_byte(input logic [7:0] din);
        case (pos_count)
            0: fmt_tag = {8'h00, din};
            1: fmt_tag[15:8] = din;
            2: chan_count = {8'h00, din};
            3: chan_count[15:8] = din;
            4: rate_field = {24'h0, din};
            5, 6, 7: rate_field[8 * (int'(pos_count) - 4) +: 8] = din;
            14: depth_field = {8'h00, din};
            15: depth_field[15:8] = din;
            default: ;
        endcase
        if (pos_count < 32'd15) begin
            pos_count++;
            return;
        end
        pos_count = '0;
        if (fmt_tag != 16'd1) begin
            raise_fault(FAULT_TAG);
        end else if (chan_count != 16'd1 && chan_count != 16'd2) begin
            raise_fault(FAULT_CHANNELS);
        end else if (rate_field == '0) begin
            raise_fault(FAULT_RATE);
        end else if (depth_field != 16'd8 && depth_field != 16'd16) begin
            raise_fault(FAULT_BITS);
        end else if (size_left > FMT_BODY_BYTES) begin
            size_left = size_left - FMT_BODY_BYTES;
            phase     = ST_FMT_REST;
        end else begin
            phase = ST_DATA_HDR;
        end
    endfunction

    function automatic void take_data_byte(input logic [7:0] din);
        logic        got_sample;
        logic [15:0] smp;
        logic [31:0] pos;
        got_sample = 1'b0;
        smp        = '0;
        pos        = pos_count;
        pos_count++;
        data_remaining--;
        if (depth_field != 16'd16) begin
            smp        = {din ^ SIGN_FLIP, din};
            got_sample = 1'b1;
        end else if (!pos[0]) begin
            low_hold = din;
        end else begin
            smp        = {din, low_hold};
            got_sample = 1'b1;
        end
        if (got_sample) begin
            if (chan_count == 16'd2 && !right_pending) begin
                left_keep     = smp;
                right_pending = 1'b1;
            end else begin
                word_out.kind  = KIND_FRAME;
                word_out.left  = (chan_count == 16'd2) ? left_keep : smp;
                word_out.right = smp;
                word_ready     = 1'b1;
                right_pending  = 1'b0;
            end
        end
        if (data_remaining == '0) begin
            phase = ST_DONE;
            if (word_ready) begin
                word_out.data_done = 1'b1;
            end
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] din, input logic eof);
        logic head_done;
        word_out   = '0;
        word_ready = 1'b0;
        case (phase)
            ST_FILE_HDR: begin
                if (pos_count < 32'd4 || pos_count >= 32'd8) begin
                    tag_shift = {tag_shift[23:0], din};
                end
                if (pos_count == 32'd3 && tag_shift != TAG_RIFF) begin
                    raise_fault(FAULT_NOT_WAVE);
                end else if (pos_count >= 32'd11) begin
                    pos_count = '0;
                    if (tag_shift != TAG_WAVE) begin
                        raise_fault(FAULT_NOT_WAVE);
                    end else begin
                        phase = ST_FMT_HDR;
                    end
                end else begin
                    pos_count++;
                end
            end
            ST_FMT_HDR: begin
                head_done = take_chunk_head(din);
                if (head_done && size_left != '0) begin
                    if (tag_shift != TAG_FMT) begin
                        phase = ST_FMT_SKIP;
                    end else if (size_left < FMT_BODY_BYTES) begin
                        raise_fault(FAULT_FMT);
                    end else begin
                        phase = ST_FMT_BODY;
                    end
                end
            end
            ST_FMT_SKIP: begin
                size_left--;
                if (size_left == '0) begin
                    phase = ST_FMT_HDR;
                end
            end
            ST_FMT_BODY: take_fmt_byte(din);
            ST_FMT_REST, ST_DATA_SKIP: begin
                size_left--;
                if (size_left == '0) begin
                    phase = ST_DATA_HDR;
                end
            end
            ST_DATA_HDR: begin
                head_done = take_chunk_head(din);
                if (head_done && size_left != '0) begin
                    if (tag_shift != TAG_DATA) begin
                        phase = ST_DATA_SKIP;
                    end else if (size_left == SIZE_UNBOUNDED) begin
                        raise_fault(FAULT_UNBOUNDED);
                    end else begin
                        data_remaining        = size_left;
                        pos_count             = '0;
                        right_pending         = 1'b0;
                        phase                 = ST_SAMPLES;
                        word_out.kind         = KIND_FORMAT;
                        word_out.sample_rate  = rate_field;
                        word_out.stereo       = (chan_count == 16'd2);
                        word_out.wide_samples = (depth_field == 16'd16);
                        word_ready            = 1'b1;
                    end
                end
            end
            ST_SAMPLES: take_data_byte(din);
            default: ;
        endcase
        if (eof) begin
            if (!word_ready) begin
                case (phase)
                    ST_FILE_HDR: raise_fault(FAULT_NOT_WAVE);
                    ST_FMT_HDR, ST_FMT_SKIP, ST_FMT_BODY: raise_fault(FAULT_FMT);
                    ST_FMT_REST, ST_DATA_HDR, ST_DATA_SKIP: raise_fault(FAULT_NO_DATA);
                    default: begin
                        word_out.kind = KIND_END;
                        word_ready    = 1'b1;
                    end
                endcase
            end
            word_out.input_ended = 1'b1;
            clear_parser();
        end
    endfunction

    task automatic put8(input logic [7:0] v);
        wav_image.push_back(v);
    endtask

    task automatic put16(input logic [15:0] v);
        put8(v[7:0]);
        put8(v[15:8]);
    endtask

    task automatic put32(input logic [31:0] v);
        put16(v[15:0]);
        put16(v[31:16]);
    endtask

    task automatic put_tag(input logic [31:0] id);
        put8(id[31:24]);
        put8(id[23:16]);
        put8(id[15:8]);
        put8(id[7:0]);
    endtask

    function automatic logic [7:0] sample_byte();
        case ($urandom_range(0, 11))
            0: return 8'h00;
            1: return 8'h7F;
            2: return 8'h80;
            3: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // A zero-size chunk may carry the sought tag, since such chunks are passed over.
    task automatic add_chunk(input logic [31:0] target, input logic [31:0] other);
        logic [31:0] id;
        logic [31:0] len;
        int          pick;
        pick = $urandom_range(0, 39);
        len  = (pick == 0) ? SIZE_UNBOUNDED : 32'($urandom_range(0, 5));
        if (len == '0 && pick < 20) begin
            id = target;
        end else if (pick < 12) begin
            id = other;
        end else begin
            do id = $urandom; while (id == target);
        end
        put_tag(id);
        put32(len);
        if (len != SIZE_UNBOUNDED) begin
            repeat (len) put8(8'($urandom));
        end
    endtask

    task automatic build_file();
        t_shape      shape;
        int          r;
        int          n;
        logic [15:0] ftag;
        logic [15:0] chans;
        logic [15:0] depth;
        logic [31:0] rate;
        logic [31:0] fsize;
        logic [31:0] dsize;
        r     = $urandom_range(0, 24);
        shape = (r <= int'(SHAPE_SHORT_DATA)) ? t_shape'(r) : SHAPE_CLEAN;
        if (shape == SHAPE_NOISE) begin
            repeat ($urandom_range(1, 20)) put8(8'($urandom));
            return;
        end
        put_tag(TAG_RIFF);
        put32($urandom);
        put_tag(TAG_WAVE);
        if (shape == SHAPE_BAD_HEADER) begin
            n = $urandom_range(0, 7);
            if (n >= 4) n += 4;
            wav_image[n] = wav_image[n] ^ 8'($urandom_range(1, 255));
        end
        repeat ($urandom_range(0, 2)) add_chunk(TAG_FMT, TAG_DATA);

        ftag = 16'd1;
        if (shape == SHAPE_BAD_TAG) begin
            ftag = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(2, 65535));
        end
        chans = 16'($urandom_range(1, 2));
        if (shape == SHAPE_BAD_CHANNELS) begin
            n     = $urandom_range(0, 2);
            chans = (n == 0) ? 16'd0 : (n == 1) ? 16'd3 : 16'($urandom_range(3, 65535));
        end
        do rate = $urandom; while (rate == '0);
        if ($urandom_range(0, 7) == 0) rate = 32'hFFFF_FFFF;
        if (shape == SHAPE_ZERO_RATE) rate = '0;
        depth = ($urandom_range(0, 1) == 0) ? 16'd8 : 16'd16;
        if (shape == SHAPE_BAD_DEPTH) begin
            n     = $urandom_range(0, 2);
            depth = (n == 0) ? 16'd0 : (n == 1) ? 16'd24 : 16'($urandom_range(17, 65535));
        end
        fsize = FMT_BODY_BYTES;
        if (shape == SHAPE_SHORT_FMT) begin
            fsize = $urandom_range(1, 15);
        end else if ($urandom_range(0, 3) == 0) begin
            fsize = fsize + $urandom_range(1, 6);
        end

        put_tag(TAG_FMT);
        put32(fsize);
        put16(ftag);
        put16(chans);
        put32(rate);
        put32($urandom);
        put16(16'($urandom));
        put16(depth);
        if (fsize < FMT_BODY_BYTES) begin
            repeat (FMT_BODY_BYTES - fsize) void'(wav_image.pop_back());
        end else begin
            repeat (fsize - FMT_BODY_BYTES) put8(8'($urandom));
        end
        repeat ($urandom_range(0, 2)) add_chunk(TAG_DATA, TAG_FMT);
        if (shape == SHAPE_NO_DATA) return;

        if (shape == SHAPE_UNBOUNDED) begin
            dsize = SIZE_UNBOUNDED;
        end else if ($urandom_range(0, 7) == 0) begin
            dsize = $urandom_range(17, 48);
        end else begin
            dsize = $urandom_range(1, 16);
        end
        put_tag(TAG_DATA);
        put32(dsize);
        if (shape == SHAPE_UNBOUNDED) begin
            n = $urandom_range(0, 3);
        end else if (shape == SHAPE_SHORT_DATA) begin
            n = $urandom_range(0, dsize - 1);
        end else begin
            n = dsize + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
        end
        repeat (n) put8(sample_byte());
        if (shape == SHAPE_CUT) begin
            n = $urandom_range(1, wav_image.size());
            while (wav_image.size() > n) void'(wav_image.pop_back());
        end
    endtask

    task automatic ship_file();
        foreach (wav_image[k]) begin
            pending_bytes.push_back('{value: wav_image[k], last: (k == wav_image.size() - 1)});
        end
        wav_image.delete();
    endtask

    function automatic bit idling_on();
        return (sent_count + TAIL_QUIET < items_total)
            && (sent_count < CALM_FROM || sent_count >= CALM_TO);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("[%0t] result %0d: %s is %0h, expected %0h",
                     $time, checked_count, what, got, want);
        end
    endtask

    task automatic compare_word(input t_result got, input t_result want);
        if (got.kind !== want.kind)
            report_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.left !== want.left)
            report_mismatch("left", {16'h0, got.left}, {16'h0, want.left});
        if (got.right !== want.right)
            report_mismatch("right", {16'h0, got.right}, {16'h0, want.right});
        if (got.sample_rate !== want.sample_rate)
            report_mismatch("sample_rate", got.sample_rate, want.sample_rate);
        if (got.stereo !== want.stereo)
            report_mismatch("stereo", 32'(got.stereo), 32'(want.stereo));
        if (got.wide_samples !== want.wide_samples)
            report_mismatch("wide_samples", 32'(got.wide_samples), 32'(want.wide_samples));
        if (got.fault_code !== want.fault_code)
            report_mismatch("fault_code", 32'(got.fault_code), 32'(want.fault_code));
        if (got.data_done !== want.data_done)
            report_mismatch("data_done", 32'(got.data_done), 32'(want.data_done));
        if (got.input_ended !== want.input_ended)
            report_mismatch("input_ended", 32'(got.input_ended), 32'(want.input_ended));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                parse_byte(i_in_byte, i_end_of_input);
                if (word_ready) begin
                    expected_words.push_back(word_out);
                end
                sent_count++;
                if (sent_count == DRAIN_AT) drain_wait = 1'b1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (drain_wait) begin
                    if (expected_words.size() == 0) drain_wait = 1'b0;
                    i_in_valid <= 1'b0;
                end else if (src_gap != 0) begin
                    src_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_bytes.size() != 0
                             && (!idling_on() || $urandom_range(0, 5) != 0)) begin
                    next_item = pending_bytes.pop_front();
                    i_in_byte      <= next_item.value;
                    i_end_of_input <= next_item.last;
                    i_in_valid     <= 1'b1;
                end else begin
                    if (pending_bytes.size() != 0) src_gap = $urandom_range(0, 7);
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                seen_word.kind         = o_kind;
                seen_word.left         = o_left;
                seen_word.right        = o_right;
                seen_word.sample_rate  = o_sample_rate;
                seen_word.stereo       = o_stereo;
                seen_word.wide_samples = o_wide_samples;
                seen_word.fault_code   = o_fault_code;
                seen_word.data_done    = o_data_done;
                seen_word.input_ended  = o_input_ended;
                if (expected_words.size() == 0) begin
                    report_mismatch("word with none expected, kind", 32'(o_kind), '0);
                end else begin
                    compare_word(seen_word, expected_words.pop_front());
                end
                checked_count++;
            end
            if (!long_hold_done && sent_count >= HOLD_AT) begin
                long_hold_done = 1'b1;
                sink_hold      = LONG_HOLD;
            end
            if (sink_hold != 0) begin
                sink_hold--;
                i_out_stall <= 1'b1;
            end else if (idling_on() && $urandom_range(0, 5) == 0) begin
                sink_hold = $urandom_range(0, 7);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        clear_parser();
        put8(8'h52);
        ship_file();
        put_tag(TAG_RIFF ^ 32'h1);
        put8(8'hFF);
        ship_file();
        put_tag(TAG_RIFF);
        put32(SIZE_UNBOUNDED);
        put_tag(TAG_WAVE ^ 32'h100);
        ship_file();
        put8(8'h00);
        put8(8'hFF);
        ship_file();
        while (pending_bytes.size() < RANDOM_BYTES) begin
            build_file();
            ship_file();
        end
        items_total = pending_bytes.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (sent_count != items_total || expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
